>>> sv/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared types, constants and helper functions for the differential path
// follower.
// ----------------------------------------------------------------------------
package dpf_pkg;

    localparam int IN_DATA_W  = 328;
    localparam int OUT_DATA_W = 64;
    localparam int NSTAGE     = 11;

    localparam logic [29:0] RAD2DEG_Q24 = 30'd961264012;
    localparam logic [23:0] DEG180_Q16  = 24'd11796480;
    localparam logic [24:0] DEG360_Q16  = 25'd23592960;
    localparam logic [20:0] MOD_OFFSET  = 21'd524295;
    localparam logic [18:0] RECIP45_Q24 = 19'd372827;

    typedef enum logic
    {
        OP_CAPTURE = 1'b0,
        OP_STEP    = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        REG_VELOCITY_FF_GAIN   = 3'd0,
        REG_ACCEL_FF_GAIN      = 3'd1,
        REG_POSITION_GAIN_FWD  = 3'd2,
        REG_POSITION_GAIN_REV  = 3'd3,
        REG_HEADING_GAIN_FWD   = 3'd4,
        REG_HEADING_GAIN_REV   = 3'd5,
        REG_INCHES_PER_TICK    = 3'd6,
        REG_TICKS_RATE_PER_IPS = 3'd7
    } cfg_idx_t;

    typedef struct packed
    {
        logic [23:0] velocity_ff_gain;
        logic [23:0] accel_ff_gain;
        logic [23:0] position_gain_fwd;
        logic [23:0] position_gain_rev;
        logic [23:0] heading_gain_fwd;
        logic [23:0] heading_gain_rev;
        logic [31:0] inches_per_tick;
        logic [31:0] ticks_rate_per_ips;
    } dpf_cfg_t;

    typedef struct packed
    {
        logic [6:0]  pad;
        logic [31:0] gyro_yaw;
        logic [31:0] right_encoder;
        logic [31:0] left_encoder;
        logic        reverse_mode;
        logic [31:0] target_heading_rad;
        logic [31:0] right_target_acc;
        logic [31:0] right_target_vel;
        logic [31:0] right_target_pos;
        logic [31:0] left_target_acc;
        logic [31:0] left_target_vel;
        logic [31:0] left_target_pos;
    } in_word_t;

    typedef struct packed
    {
        logic [32:0] pos;
        logic [32:0] vel;
        logic [32:0] acc;
        logic [31:0] delta;
    } side_in_t;

    function automatic logic [31:0] sat32(input logic [63:0] x);
        logic [31:0] r;
        if ((&x[63:31]) || (~|x[63:31]))
        begin
            r = x[31:0];
        end
        else if (x[63])
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [32:0] ext33(input logic [31:0] x);
        return {x[31], x};
    endfunction

    function automatic logic [32:0] neg33(input logic [31:0] x);
        return 33'd0 - {x[31], x};
    endfunction

    // Remainder by 45 from an estimated quotient that is exact or one short.
    function automatic logic [5:0] mod45(input logic [20:0] hp, input logic [15:0] q0);
        logic [21:0] t;
        t = {1'b0, hp} - (22'(q0) * 22'd45);
        if (t >= 22'd45)
        begin
            t = t - 22'd45;
        end
        return t[5:0];
    endfunction

endpackage

>>> sv/differential_path_follower_unit.sv
// ----------------------------------------------------------------------------
// differential_path_follower_unit
// Feedforward plus proportional path follower for a two-sided drive with
// heading correction, as a fully pipelined stream block.
// ----------------------------------------------------------------------------
// A step word (tuser high) yields one result word, and a new word may be
// accepted in every cycle while the output is not held. A capture word
// (tuser low) stores the encoder counts and gyro yaw as the origin and
// yields no result; step words accepted after it use the new origin. The
// pipeline has eleven stages and the output register; the longest chain
// is the heading path, which reduces degrees modulo 360 and wraps the
// heading error before the gain is applied. When the output word is not
// taken the whole pipeline holds, so input ready follows output ready in
// that case. The user must write configuration registers through the
// write port only while no step word is in flight; the block does not enforce it.
module differential_path_follower_unit
    import dpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [2:0]            cfg_addr,
    input  logic [31:0]           cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // From bit 0: left_target_pos, left_target_vel, left_target_acc,
    // right_target_pos, right_target_vel, right_target_acc,
    // target_heading_rad, reverse_mode, left_encoder, right_encoder,
    // gyro_yaw, then zero padding.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op.
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // From bit 0: left_velocity_cmd, right_velocity_cmd.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    dpf_cfg_t    cfg_reg;
    in_word_t    in_w;
    logic        pipe_en;
    logic        in_accept;
    logic        is_step;

    logic [31:0] left_origin_reg;
    logic [31:0] right_origin_reg;
    logic [31:0] heading_origin_reg;

    logic [NSTAGE-1:0] stage_valid_reg;
    logic [NSTAGE-1:0] stage_valid_next;

    side_in_t    left_in_next;
    side_in_t    right_in_next;
    side_in_t    left_in_reg;
    side_in_t    right_in_reg;
    logic        rev_reg;
    logic [31:0] rad_reg;
    logic [32:0] gyro_diff_next;
    logic [32:0] gyro_diff_reg;

    logic [31:0] hterm;
    logic [31:0] left_ticks;
    logic [31:0] right_ticks;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    assign in_w          = in_word_t'(s_axis_tdata);
    assign pipe_en       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = pipe_en;
    assign in_accept     = s_axis_tvalid && pipe_en;
    assign is_step       = (op_t'(s_axis_tuser) == OP_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_VELOCITY_FF_GAIN:   cfg_reg.velocity_ff_gain   <= cfg_wdata[23:0];
                REG_ACCEL_FF_GAIN:      cfg_reg.accel_ff_gain      <= cfg_wdata[23:0];
                REG_POSITION_GAIN_FWD:  cfg_reg.position_gain_fwd  <= cfg_wdata[23:0];
                REG_POSITION_GAIN_REV:  cfg_reg.position_gain_rev  <= cfg_wdata[23:0];
                REG_HEADING_GAIN_FWD:   cfg_reg.heading_gain_fwd   <= cfg_wdata[23:0];
                REG_HEADING_GAIN_REV:   cfg_reg.heading_gain_rev   <= cfg_wdata[23:0];
                REG_INCHES_PER_TICK:    cfg_reg.inches_per_tick    <= cfg_wdata;
                REG_TICKS_RATE_PER_IPS: cfg_reg.ticks_rate_per_ips <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_origin_reg    <= '0;
            right_origin_reg   <= '0;
            heading_origin_reg <= '0;
        end
        else if (in_accept && !is_step)
        begin
            left_origin_reg    <= in_w.left_encoder;
            right_origin_reg   <= in_w.right_encoder;
            heading_origin_reg <= in_w.gyro_yaw;
        end
    end

    // Reverse mode swaps the sides and negates every position, velocity and acceleration target.
    always_comb
    begin
        if (in_w.reverse_mode)
        begin
            left_in_next.pos  = neg33(in_w.right_target_pos);
            left_in_next.vel  = neg33(in_w.right_target_vel);
            left_in_next.acc  = neg33(in_w.right_target_acc);
            right_in_next.pos = neg33(in_w.left_target_pos);
            right_in_next.vel = neg33(in_w.left_target_vel);
            right_in_next.acc = neg33(in_w.left_target_acc);
        end
        else
        begin
            left_in_next.pos  = ext33(in_w.left_target_pos);
            left_in_next.vel  = ext33(in_w.left_target_vel);
            left_in_next.acc  = ext33(in_w.left_target_acc);
            right_in_next.pos = ext33(in_w.right_target_pos);
            right_in_next.vel = ext33(in_w.right_target_vel);
            right_in_next.acc = ext33(in_w.right_target_acc);
        end
        left_in_next.delta  = in_w.left_encoder - left_origin_reg;
        right_in_next.delta = in_w.right_encoder - right_origin_reg;
    end

    assign gyro_diff_next = ext33(in_w.gyro_yaw) - ext33(heading_origin_reg);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            left_in_reg   <= left_in_next;
            right_in_reg  <= right_in_next;
            rev_reg       <= in_w.reverse_mode;
            rad_reg       <= in_w.target_heading_rad;
            gyro_diff_reg <= gyro_diff_next;
        end
    end

    assign stage_valid_next = {stage_valid_reg[NSTAGE-2:0], s_axis_tvalid && is_step};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    dpf_heading u_heading
    (
        .clk       (clk),
        .en        (pipe_en),
        .cfg       (cfg_reg),
        .rev       (rev_reg),
        .rad       (rad_reg),
        .gyro_diff (gyro_diff_reg),
        .hterm     (hterm)
    );

    dpf_side u_left
    (
        .clk         (clk),
        .en          (pipe_en),
        .cfg         (cfg_reg),
        .side_in     (left_in_reg),
        .rev         (rev_reg),
        .heading_add (1'b0),
        .hterm       (hterm),
        .ticks       (left_ticks)
    );

    dpf_side u_right
    (
        .clk         (clk),
        .en          (pipe_en),
        .cfg         (cfg_reg),
        .side_in     (right_in_reg),
        .rev         (rev_reg),
        .heading_add (1'b1),
        .hterm       (hterm),
        .ticks       (right_ticks)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            m_valid_reg <= stage_valid_reg[NSTAGE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m_data_reg <= {right_ticks, left_ticks};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_capture_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (op_t'(s_axis_tuser) == OP_CAPTURE))
        |=> !stage_valid_reg[0])
        else $error("capture word entered the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(stage_valid_reg))
        else $error("pipeline valid bits moved during a stall");

    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(stage_valid_reg[NSTAGE-1]))
        else $error("output word without a word in the last stage");
`endif

endmodule

>>> sv/dpf_heading.sv
// ----------------------------------------------------------------------------
// dpf_heading
// Heading path: target heading in degrees, reverse turn, robot heading
// wrap, error wrap and the saturated heading correction term.
// ----------------------------------------------------------------------------
module dpf_heading
    import dpf_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  dpf_cfg_t    cfg,
    input  logic        rev,
    input  logic [31:0] rad,
    input  logic [32:0] gyro_diff,
    output logic [31:0] hterm
);

    localparam logic signed [38:0] LIM_HI = $signed({15'b0, DEG180_Q16});
    localparam logic signed [38:0] LIM_LO = -LIM_HI;
    localparam logic signed [38:0] FULL   = $signed({14'b0, DEG360_Q16});

    logic signed [61:0] deg_prod_next;
    logic [20:0]        hpr_next;
    logic [39:0]        qpr_next;
    logic signed [61:0] deg_prod_reg;
    logic [20:0]        hpr_reg;
    logic [39:0]        qpr_reg;
    logic [18:0]        glow_reg;
    logic               rev2_reg;

    logic [37:0] deg_w;
    logic [38:0] x_w;
    logic [20:0] hpx_next;
    logic [24:0] robot_next;
    logic [37:0] deg3_reg;
    logic        xneg3_reg;
    logic [18:0] xlow3_reg;
    logic [20:0] hpx3_reg;
    logic [24:0] robot3_reg;
    logic        rev3_reg;

    logic [39:0] qpx_next;
    logic [37:0] deg4_reg;
    logic        xneg4_reg;
    logic [18:0] xlow4_reg;
    logic [20:0] hpx4_reg;
    logic [39:0] qpx4_reg;
    logic [24:0] robot4_reg;
    logic        rev4_reg;

    logic [24:0] rfloor_next;
    logic [37:0] deg5_reg;
    logic        xneg5_reg;
    logic [24:0] rfloor5_reg;
    logic [24:0] robot5_reg;
    logic        rev5_reg;

    logic [25:0] rtrunc;
    logic [37:0] degsel_next;
    logic [37:0] degsel6_reg;
    logic [24:0] robot6_reg;
    logic        rev6_reg;

    logic signed [38:0] diff;
    logic signed [38:0] err_next;
    logic [38:0]        err7_reg;
    logic               rev7_reg;

    logic [23:0]        hg;
    logic signed [43:0] ph_next;
    logic [43:0]        pl_next;
    logic [43:0]        ph8_reg;
    logic [43:0]        pl8_reg;

    logic [63:0] full_w;
    logic [31:0] hterm_next;
    logic [31:0] hterm_reg;

    assign deg_prod_next = $signed(rad) * $signed({1'b0, RAD2DEG_Q24});
    assign hpr_next      = {{7{gyro_diff[32]}}, gyro_diff[32:19]} + MOD_OFFSET;
    assign qpr_next      = hpr_next * RECIP45_Q24;

    assign deg_w      = deg_prod_reg[61:24];
    assign x_w        = {deg_w[37], deg_w} + {15'b0, DEG180_Q16};
    assign hpx_next   = {x_w[38], x_w[38:19]} + MOD_OFFSET;
    assign robot_next = {mod45(hpr_reg, qpr_reg[39:24]), glow_reg};

    assign qpx_next = hpx3_reg * RECIP45_Q24;

    assign rfloor_next = {mod45(hpx4_reg, qpx4_reg[39:24]), xlow4_reg};

    assign rtrunc = (xneg5_reg && (|rfloor5_reg))
                    ? ({1'b0, rfloor5_reg} - {1'b0, DEG360_Q16})
                    : {1'b0, rfloor5_reg};
    assign degsel_next = rev5_reg ? {{12{rtrunc[25]}}, rtrunc} : deg5_reg;

    assign diff = $signed({degsel6_reg[37], degsel6_reg}) - $signed({14'b0, robot6_reg});

    always_comb
    begin
        priority if (diff < LIM_LO)
        begin
            err_next = diff + FULL;
        end
        else if (diff > LIM_HI)
        begin
            err_next = diff - FULL;
        end
        else
        begin
            err_next = diff;
        end
    end

    assign hg      = rev7_reg ? cfg.heading_gain_rev : cfg.heading_gain_fwd;
    assign ph_next = $signed(err7_reg[38:20]) * $signed({1'b0, hg});
    assign pl_next = err7_reg[19:0] * hg;

    assign full_w     = {ph8_reg, 20'b0} + {20'b0, pl8_reg};
    assign hterm_next = sat32({{16{full_w[63]}}, full_w[63:16]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_prod_reg <= deg_prod_next;
            hpr_reg      <= hpr_next;
            qpr_reg      <= qpr_next;
            glow_reg     <= gyro_diff[18:0];
            rev2_reg     <= rev;

            deg3_reg   <= deg_w;
            xneg3_reg  <= x_w[38];
            xlow3_reg  <= x_w[18:0];
            hpx3_reg   <= hpx_next;
            robot3_reg <= robot_next;
            rev3_reg   <= rev2_reg;

            deg4_reg   <= deg3_reg;
            xneg4_reg  <= xneg3_reg;
            xlow4_reg  <= xlow3_reg;
            hpx4_reg   <= hpx3_reg;
            qpx4_reg   <= qpx_next;
            robot4_reg <= robot3_reg;
            rev4_reg   <= rev3_reg;

            deg5_reg    <= deg4_reg;
            xneg5_reg   <= xneg4_reg;
            rfloor5_reg <= rfloor_next;
            robot5_reg  <= robot4_reg;
            rev5_reg    <= rev4_reg;

            degsel6_reg <= degsel_next;
            robot6_reg  <= robot5_reg;
            rev6_reg    <= rev5_reg;

            err7_reg <= err_next;
            rev7_reg <= rev6_reg;

            ph8_reg <= ph_next;
            pl8_reg <= pl_next;

            hterm_reg <= hterm_next;
        end
    end

    assign hterm = hterm_reg;

endmodule

>>> sv/dpf_side.sv
// ----------------------------------------------------------------------------
// dpf_side
// One side of the drive: travelled distance, feedforward and position
// terms, heading correction and conversion to ticks per 100 ms.
// ----------------------------------------------------------------------------
module dpf_side
    import dpf_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  dpf_cfg_t    cfg,
    input  side_in_t    side_in,
    input  logic        rev,
    input  logic        heading_add,
    input  logic [31:0] hterm,
    output logic [31:0] ticks
);

    logic signed [63:0] trav_prod_next;
    logic signed [57:0] ffv_next;
    logic signed [57:0] ffa_next;
    logic [63:0]        trav_prod_reg;
    logic [57:0]        ffv_reg;
    logic [57:0]        ffa_reg;
    logic [32:0]        pos2_reg;
    logic               rev2_reg;

    logic [31:0]        trav_next;
    logic signed [42:0] ffsum_next;
    logic [31:0]        trav3_reg;
    logic [42:0]        ffsum3_reg;
    logic [32:0]        pos3_reg;
    logic               rev3_reg;

    logic signed [33:0] errp_next;
    logic [33:0]        errp4_reg;
    logic [42:0]        ffsum4_reg;
    logic               rev4_reg;

    logic [23:0]        kp;
    logic signed [58:0] kpp_next;
    logic [58:0]        kpp5_reg;
    logic [42:0]        ffsum5_reg;

    logic signed [43:0] part_next;
    logic [43:0]        part_pipe_reg [4];

    logic [44:0]        hx;
    logic [44:0]        px;
    logic [44:0]        sum_w;
    logic [31:0]        cmd_next;
    logic [31:0]        cmd_reg;

    logic signed [63:0] prod_next;
    logic [63:0]        prod_reg;

    assign trav_prod_next = $signed(side_in.delta) * $signed({1'b0, cfg.inches_per_tick});
    assign ffv_next       = $signed(side_in.vel) * $signed({1'b0, cfg.velocity_ff_gain});
    assign ffa_next       = $signed(side_in.acc) * $signed({1'b0, cfg.accel_ff_gain});

    assign trav_next  = sat32({{8{trav_prod_reg[63]}}, trav_prod_reg[63:8]});
    assign ffsum_next = $signed({ffv_reg[57], ffv_reg[57:16]})
                      + $signed({ffa_reg[57], ffa_reg[57:16]});

    assign errp_next = $signed({pos3_reg[32], pos3_reg}) - $signed({{2{trav3_reg[31]}}, trav3_reg});

    assign kp       = rev4_reg ? cfg.position_gain_rev : cfg.position_gain_fwd;
    assign kpp_next = $signed(errp4_reg) * $signed({1'b0, kp});

    assign part_next = $signed({ffsum5_reg[42], ffsum5_reg}) + $signed({kpp5_reg[58], kpp5_reg[58:16]});

    assign hx       = {{13{hterm[31]}}, hterm};
    assign px       = {part_pipe_reg[3][43], part_pipe_reg[3]};
    assign sum_w    = heading_add ? (px + hx) : (px - hx);
    assign cmd_next = sat32({{19{sum_w[44]}}, sum_w});

    assign prod_next = $signed(cmd_reg) * $signed({1'b0, cfg.ticks_rate_per_ips});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trav_prod_reg <= trav_prod_next;
            ffv_reg       <= ffv_next;
            ffa_reg       <= ffa_next;
            pos2_reg      <= side_in.pos;
            rev2_reg      <= rev;

            trav3_reg  <= trav_next;
            ffsum3_reg <= ffsum_next;
            pos3_reg   <= pos2_reg;
            rev3_reg   <= rev2_reg;

            errp4_reg  <= errp_next;
            ffsum4_reg <= ffsum3_reg;
            rev4_reg   <= rev3_reg;

            kpp5_reg   <= kpp_next;
            ffsum5_reg <= ffsum4_reg;

            part_pipe_reg[0] <= part_next;
            part_pipe_reg[1] <= part_pipe_reg[0];
            part_pipe_reg[2] <= part_pipe_reg[1];
            part_pipe_reg[3] <= part_pipe_reg[2];

            cmd_reg  <= cmd_next;
            prod_reg <= prod_next;
        end
    end

    assign ticks = {{8{prod_reg[63]}}, prod_reg[63:40]};

endmodule

>>> tb/differential_path_follower_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_path_follower_unit_tb
// Self-checking bench for the differential path follower. A short table of
// directed words runs first, with zero results typed in for the reset
// configuration and the rest checked against a behavioural predictor of the
// feedforward, position and heading terms. Random origin captures and control
// steps follow under several register settings, including all-ones, with
// random gaps on both streams and one long receiver hold-off that backs the
// pipeline up into its input.
// ----------------------------------------------------------------------------
module differential_path_follower_unit_tb;
    import dpf_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_GAP        = 17;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_WORDS    = 215;
    localparam int PRESSURE_WORDS = 40;
    localparam int RESET_ROWS     = 5;
    localparam int NUM_PHASES     = 6;
    localparam int MAX_PRINTED    = 40;

    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;

    localparam longint DEG180    = 64'sd11796480;
    localparam longint DEG360    = 64'sd23592960;
    localparam longint RAD_TO_DEG = 64'sd961264012;
    localparam longint LIM_HI    = 64'sh7FFF_FFFF;
    localparam longint LIM_LO    = -64'sh8000_0000;

    typedef struct packed
    {
        logic [31:0] right;
        logic [31:0] left;
    } cmd_pair_t;

    typedef struct
    {
        op_t       op;
        in_word_t  w;
        bit        typed;
        cmd_pair_t exp;
    } stim_row_t;

    typedef enum
    {
        SET_ALL_MAX,
        SET_TYPICAL,
        SET_FULL_RANDOM,
        SET_MIXED
    } setting_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [2:0]            cfg_addr;
    logic [31:0]           cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    longint vel_ff_gain   = 0;
    longint acc_ff_gain   = 0;
    longint pos_gain_fwd  = 0;
    longint pos_gain_rev  = 0;
    longint head_gain_fwd = 0;
    longint head_gain_rev = 0;
    longint inch_per_tick = 0;
    longint tick_rate     = 0;

    logic [31:0] origin_left  = '0;
    logic [31:0] origin_right = '0;
    logic [31:0] origin_yaw   = '0;

    cmd_pair_t expected_cmds [$];
    stim_row_t stim_rows [$];
    cmd_pair_t got_cmds;
    cmd_pair_t want_cmds;

    setting_t phase_plan [NUM_PHASES] = '{SET_ALL_MAX, SET_TYPICAL, SET_FULL_RANDOM,
                                          SET_MIXED, SET_TYPICAL, SET_MIXED};

    int src_gap_max  = MAX_GAP;
    int sink_gap_max = MAX_GAP;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;
    int n_errors     = 0;
    int n_words      = 0;
    int n_captures   = 0;
    int n_reversed   = 0;
    int n_results    = 0;
    int n_settings   = 1;

    differential_path_follower_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic longint sx32(input logic [31:0] v);
        return $signed(v);
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > LIM_HI)
            return LIM_HI;
        if (x < LIM_LO)
            return LIM_LO;
        return x;
    endfunction

    function automatic longint side_ticks(input longint pos, vel, acc, travelled, kp, hterm,
                                          input bit add_heading);
        longint sum;
        sum = ((vel_ff_gain * vel) >>> 16) + ((acc_ff_gain * acc) >>> 16)
            + ((kp * (pos - travelled)) >>> 16);
        if (add_heading)
            sum = sum + hterm;
        else
            sum = sum - hterm;
        return clamp32((clamp32(sum) * tick_rate) >>> 40);
    endfunction

    function automatic cmd_pair_t predict_commands(input in_word_t w);
        longint deg, robot, err, hterm, kp, hg;
        longint lp, lv, la, rp, rv, ra, trav_l, trav_r;
        logic [31:0] dl, dr;
        cmd_pair_t c;
        deg = (sx32(w.target_heading_rad) * RAD_TO_DEG) >>> 24;
        if (w.reverse_mode)
        begin
            lp = -sx32(w.right_target_pos);
            lv = -sx32(w.right_target_vel);
            la = -sx32(w.right_target_acc);
            rp = -sx32(w.left_target_pos);
            rv = -sx32(w.left_target_vel);
            ra = -sx32(w.left_target_acc);
            deg = (deg + DEG180) % DEG360;
            kp = pos_gain_rev;
            hg = head_gain_rev;
        end
        else
        begin
            lp = sx32(w.left_target_pos);
            lv = sx32(w.left_target_vel);
            la = sx32(w.left_target_acc);
            rp = sx32(w.right_target_pos);
            rv = sx32(w.right_target_vel);
            ra = sx32(w.right_target_acc);
            kp = pos_gain_fwd;
            hg = head_gain_fwd;
        end
        dl = w.left_encoder - origin_left;
        dr = w.right_encoder - origin_right;
        trav_l = clamp32((sx32(dl) * inch_per_tick) >>> 8);
        trav_r = clamp32((sx32(dr) * inch_per_tick) >>> 8);
        robot = (sx32(w.gyro_yaw) - sx32(origin_yaw)) % DEG360;
        if (robot < 0)
            robot = robot + DEG360;
        err = deg - robot;
        if (err < -DEG180)
            err = err + DEG360;
        if (err > DEG180)
            err = err - DEG360;
        hterm = clamp32((err * hg) >>> 16);
        c.left  = 32'(side_ticks(lp, lv, la, trav_l, kp, hterm, 1'b0));
        c.right = 32'(side_ticks(rp, rv, ra, trav_r, kp, hterm, 1'b1));
        return c;
    endfunction

    function automatic logic [31:0] q16(input int whole);
        return whole * 65536;
    endfunction

    function automatic logic [31:0] rand_span(input int unsigned m);
        return $urandom_range(0, 2 * m) - m;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0, 1:
                return $urandom;
            2:
                case ($urandom_range(0, 3))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            default:
                return rand_span(100 * 65536);
        endcase
    endfunction

    function automatic void random_word(output op_t op, output in_word_t w);
        if ($urandom_range(0, 9) == 0)
            op = OP_CAPTURE;
        else
            op = OP_STEP;
        w = '0;
        w.left_target_pos  = rand_q16();
        w.left_target_vel  = rand_q16();
        w.left_target_acc  = rand_q16();
        w.right_target_pos = rand_q16();
        w.right_target_vel = rand_q16();
        w.right_target_acc = rand_q16();
        if ($urandom_range(0, 7) == 0)
            w.target_heading_rad = $urandom;
        else
            w.target_heading_rad = rand_span(7 * 65536);
        w.reverse_mode = $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0)
            w.left_encoder = $urandom;
        else
            w.left_encoder = origin_left + rand_span(20000);
        if ($urandom_range(0, 7) == 0)
            w.right_encoder = $urandom;
        else
            w.right_encoder = origin_right + rand_span(20000);
        if ($urandom_range(0, 7) == 0)
            w.gyro_yaw = $urandom;
        else
            w.gyro_yaw = origin_yaw + rand_span(720 * 65536);
    endfunction

    function automatic int gap_ceiling();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 4;
            default: return MAX_GAP;
        endcase
    endfunction

    function automatic logic [31:0] typical_value(input cfg_idx_t r);
        case (r)
            REG_INCHES_PER_TICK:    return $urandom_range(0, 1 << 22);
            REG_TICKS_RATE_PER_IPS: return $urandom_range(0, 1 << 26);
            default:                return $urandom_range(0, 1 << 18);
        endcase
    endfunction

    function automatic logic [31:0] pick_reg(input setting_t s, input cfg_idx_t r);
        logic [31:0] top;
        if (r == REG_INCHES_PER_TICK || r == REG_TICKS_RATE_PER_IPS)
            top = 32'hFFFF_FFFF;
        else
            top = 32'h00FF_FFFF;
        case (s)
            SET_ALL_MAX:     return top;
            SET_TYPICAL:     return typical_value(r);
            SET_FULL_RANDOM: return $urandom & top;
            default:
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return top;
                    2: return $urandom & top;
                    default: return typical_value(r);
                endcase
        endcase
    endfunction

    function automatic void add_row(input op_t op, input logic rev,
                                    input logic [31:0] lp, lv, la, rp, rv, ra,
                                    input logic [31:0] head, le, re, yaw,
                                    input bit typed, input cmd_pair_t exp);
        stim_row_t row;
        row.op = op;
        row.w = '0;
        row.w.left_target_pos    = lp;
        row.w.left_target_vel    = lv;
        row.w.left_target_acc    = la;
        row.w.right_target_pos   = rp;
        row.w.right_target_vel   = rv;
        row.w.right_target_acc   = ra;
        row.w.target_heading_rad = head;
        row.w.reverse_mode       = rev;
        row.w.left_encoder       = le;
        row.w.right_encoder      = re;
        row.w.gyro_yaw           = yaw;
        row.typed = typed;
        row.exp   = exp;
        stim_rows.push_back(row);
    endfunction

    task automatic write_reg(input cfg_idx_t r, input logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        case (r)
            REG_VELOCITY_FF_GAIN:   vel_ff_gain   = v[23:0];
            REG_ACCEL_FF_GAIN:      acc_ff_gain   = v[23:0];
            REG_POSITION_GAIN_FWD:  pos_gain_fwd  = v[23:0];
            REG_POSITION_GAIN_REV:  pos_gain_rev  = v[23:0];
            REG_HEADING_GAIN_FWD:   head_gain_fwd = v[23:0];
            REG_HEADING_GAIN_REV:   head_gain_rev = v[23:0];
            REG_INCHES_PER_TICK:    inch_per_tick = v;
            REG_TICKS_RATE_PER_IPS: tick_rate     = v;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_setting(input setting_t s);
        write_reg(REG_VELOCITY_FF_GAIN,   pick_reg(s, REG_VELOCITY_FF_GAIN));
        write_reg(REG_ACCEL_FF_GAIN,      pick_reg(s, REG_ACCEL_FF_GAIN));
        write_reg(REG_POSITION_GAIN_FWD,  pick_reg(s, REG_POSITION_GAIN_FWD));
        write_reg(REG_POSITION_GAIN_REV,  pick_reg(s, REG_POSITION_GAIN_REV));
        write_reg(REG_HEADING_GAIN_FWD,   pick_reg(s, REG_HEADING_GAIN_FWD));
        write_reg(REG_HEADING_GAIN_REV,   pick_reg(s, REG_HEADING_GAIN_REV));
        write_reg(REG_INCHES_PER_TICK,    pick_reg(s, REG_INCHES_PER_TICK));
        write_reg(REG_TICKS_RATE_PER_IPS, pick_reg(s, REG_TICKS_RATE_PER_IPS));
        n_settings++;
    endtask

    // Capture words give no result, so a fixed pause follows the last result.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic issue_word(input op_t op, input in_word_t w,
                              input bit typed, input cmd_pair_t typed_cmds);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_words++;
        if (op == OP_CAPTURE)
        begin
            origin_left  = w.left_encoder;
            origin_right = w.right_encoder;
            origin_yaw   = w.gyro_yaw;
            n_captures++;
        end
        else
        begin
            if (w.reverse_mode)
                n_reversed++;
            expected_cmds.push_back(typed ? typed_cmds : predict_commands(w));
        end
    endtask

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
            begin
                stall = $urandom_range(0, sink_gap_max);
            end
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_cmds = m_axis_tdata;
            n_results++;
            if (expected_cmds.size() == 0)
            begin
                flag_error($sformatf("result word %h with nothing expected", got_cmds));
            end
            else
            begin
                want_cmds = expected_cmds.pop_front();
                if (got_cmds.left !== want_cmds.left)
                    flag_error($sformatf("left command %h, expected %h",
                                         got_cmds.left, want_cmds.left));
                if (got_cmds.right !== want_cmds.right)
                    flag_error($sformatf("right command %h, expected %h",
                                         got_cmds.right, want_cmds.right));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        op_t      op;
        in_word_t w;
        cfg_we        = 1'b0;
        cfg_addr      = REG_VELOCITY_FF_GAIN;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_CAPTURE;
        rst_n         = 1'b0;

        // With every register at its reset value of zero, all commands are zero.
        add_row(OP_STEP, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '0);
        add_row(OP_STEP, 1'b0, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                S_MAX, S_MAX, S_MAX, S_MAX, 1'b1, '0);
        add_row(OP_STEP, 1'b1, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                S_MIN, S_MIN, S_MIN, S_MIN, 1'b1, '0);
        add_row(OP_CAPTURE, 1'b0, 0, 0, 0, 0, 0, 0, 0, S_MAX, S_MAX, S_MAX, 1'b0, '0);
        add_row(OP_STEP, 1'b0, q16(3), q16(2), q16(1), q16(3), q16(2), q16(1),
                0, S_MIN, S_MIN, S_MIN, 1'b1, '0);

        add_row(OP_CAPTURE, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0);
        add_row(OP_STEP, 1'b0, q16(10), q16(5), q16(1), q16(12), q16(6), q16(-1),
                0, 100, 120, 0, 1'b0, '0);
        add_row(OP_STEP, 1'b1, q16(10), q16(5), q16(1), q16(12), q16(6), q16(-1),
                0, 100, 120, 0, 1'b0, '0);
        add_row(OP_STEP, 1'b0, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                S_MAX, 0, 0, 0, 1'b0, '0);
        add_row(OP_STEP, 1'b0, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                S_MIN, 0, 0, 0, 1'b0, '0);
        add_row(OP_STEP, 1'b1, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                S_MIN, 0, 0, 0, 1'b0, '0);
        add_row(OP_STEP, 1'b0, q16(4), q16(1), 0, q16(4), q16(1), 0,
                0, 50, 50, q16(-90), 1'b0, '0);
        add_row(OP_STEP, 1'b0, q16(4), q16(1), 0, q16(4), q16(1), 0,
                205887, 50, 50, 0, 1'b0, '0);
        add_row(OP_STEP, 1'b0, q16(4), q16(1), 0, q16(4), q16(1), 0,
                q16(-3), 50, 50, q16(90), 1'b0, '0);
        add_row(OP_STEP, 1'b0, q16(4), q16(1), 0, q16(4), q16(1), 0,
                q16(6), 50, 50, q16(10), 1'b0, '0);
        add_row(OP_STEP, 1'b1, q16(4), q16(1), 0, q16(4), q16(1), 0,
                q16(3), 50, 50, q16(350), 1'b0, '0);
        add_row(OP_STEP, 1'b1, q16(4), q16(1), 0, q16(4), q16(1), 0,
                q16(-4), 50, 50, q16(200), 1'b0, '0);
        add_row(OP_CAPTURE, 1'b0, 0, 0, 0, 0, 0, 0, 0, S_MAX, S_MAX, S_MAX, 1'b0, '0);
        add_row(OP_STEP, 1'b0, q16(2), q16(1), 0, q16(2), q16(1), 0,
                0, S_MIN, S_MIN, S_MIN, 1'b0, '0);
        add_row(OP_STEP, 1'b0, q16(2), q16(1), 0, q16(2), q16(1), 0,
                0, 0, 0, 0, 1'b0, '0);
        add_row(OP_CAPTURE, 1'b0, 0, 0, 0, 0, 0, 0, 0, S_MIN, S_MIN, S_MIN, 1'b0, '0);
        add_row(OP_STEP, 1'b1, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                S_MAX, S_MAX, S_MAX, S_MAX, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            if (i == RESET_ROWS)
            begin
                settle();
                write_reg(REG_VELOCITY_FF_GAIN,   32'd65536);
                write_reg(REG_ACCEL_FF_GAIN,      32'd32768);
                write_reg(REG_POSITION_GAIN_FWD,  32'd131072);
                write_reg(REG_POSITION_GAIN_REV,  32'd98304);
                write_reg(REG_HEADING_GAIN_FWD,   32'd16384);
                write_reg(REG_HEADING_GAIN_REV,   32'd49152);
                write_reg(REG_INCHES_PER_TICK,    32'd206359);
                write_reg(REG_TICKS_RATE_PER_IPS, 32'd50331648);
                n_settings++;
            end
            issue_word(stim_rows[i].op, stim_rows[i].w, stim_rows[i].typed, stim_rows[i].exp);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            program_setting(phase_plan[p]);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (k % 64 == 0)
                begin
                    src_gap_max  = gap_ceiling();
                    sink_gap_max = gap_ceiling();
                end
                random_word(op, w);
                issue_word(op, w, 1'b0, '0);
            end
            if (p == 2)
            begin
                src_gap_max  = 0;
                hold_request = 1'b1;
                repeat (PRESSURE_WORDS)
                begin
                    random_word(op, w);
                    issue_word(OP_STEP, w, 1'b0, '0);
                end
                src_gap_max = MAX_GAP;
            end
        end

        settle();
        $display("Covered %0d input words (%0d origin captures, %0d reversed steps) and %0d",
                 n_words, n_captures, n_reversed, n_results);
        $display("command words under %0d register settings, with one %0d-cycle output hold.",
                 n_settings, HOLD_CYCLES);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
sv/dpf_pkg.sv
sv/dpf_heading.sv
sv/dpf_side.sv
sv/differential_path_follower_unit.sv
tb/differential_path_follower_unit_tb.sv
